/* hdl/random_walk_excursion_visit_counter_defines.svh */
// Assertion macros shared by the random walk excursion visit counter RTL.
// Depends on nothing; the top level takes it by include.
`ifndef RANDOM_WALK_EXCURSION_VISIT_COUNTER_DEFINES_SVH
`define RANDOM_WALK_EXCURSION_VISIT_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that cons holds in the same cycle whenever ante holds.
`define RWEVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwevc check failed");
// Checks that cons holds in the cycle after ante holds.
`define RWEVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwevc check failed");
`else
`define RWEVC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RWEVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rwevc_pkg.sv */
// Package of the random walk excursion visit counter: types, constants, helpers.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
`default_nettype none
package rwevc_pkg;

    localparam int NUM_STATES = 18;
    localparam int STATE_SPAN = 9;
    localparam int IDX_W      = 5;
    localparam int SUM_W      = 33;
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STATES - 1);
    localparam logic [IDX_W-1:0] SPAN_IDX = IDX_W'(STATE_SPAN);

    localparam logic signed [SUM_W-1:0] SUM_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 33'sh1_0000_0000;
    localparam logic signed [SUM_W-1:0] SPAN_HI = 33'sd9;
    localparam logic signed [SUM_W-1:0] SPAN_LO = -33'sd9;

    localparam logic [CFG_W-1:0] MIN_CYCLES_RESET = 32'd500;
    localparam logic [OUT_W-1:0] OUT_MAX          = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_CLOSE,
        ST_EMIT
    } rwevc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             step;
        logic             seq_bit;
        logic             close;
        logic             load;
        logic             clear;
        logic [IDX_W-1:0] emit_idx;
    } rwevc_cmd_t;

    // Walk state reported at a given result position: -9..-1, then 1..9.
    function automatic logic signed [IDX_W-1:0] idx_to_state(input logic [IDX_W-1:0] idx);
        logic signed [IDX_W-1:0] st;
        if (idx < SPAN_IDX)
        begin
            st = signed'(idx - SPAN_IDX);
        end
        else
        begin
            st = signed'(idx - SPAN_IDX + IDX_W'(1));
        end
        return st;
    endfunction

endpackage
`default_nettype wire

/* hdl/rwevc_if.sv */
// Channel interfaces of the random walk excursion visit counter: bits, results, config.
// Depends on rwevc_pkg for field widths.
`default_nettype none
interface rwevc_bit_if;
    logic valid;
    logic ready;
    logic seq_bit;
    logic last_bit;

    modport source (output valid, output seq_bit, output last_bit, input ready);
    modport sink   (input valid, input seq_bit, input last_bit, output ready);
endinterface

interface rwevc_result_if import rwevc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [IDX_W-1:0] walk_state;
    logic [OUT_W-1:0]        visit_count;
    logic [OUT_W-1:0]        cycle_count;
    logic                    applicable;
    logic                    last_result;

    modport source (output valid, output walk_state, output visit_count, output cycle_count,
                    output applicable, output last_result, input ready);
    modport sink   (input valid, input walk_state, input visit_count, input cycle_count,
                    input applicable, input last_result, output ready);
endinterface

interface rwevc_cfg_if import rwevc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/rwevc_ctrl.sv */
// Controller of the random walk excursion visit counter: accumulate, close, emit.
// Depends on rwevc_pkg for the state type and the command struct.
`default_nettype none
module rwevc_ctrl
    import rwevc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic seq_bit,
    input  wire logic last_bit,
    input  wire logic out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output rwevc_cmd_t cmd
);

    rwevc_state_t     state_reg, state_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (in_valid && last_bit)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((!out_valid_reg || out_ready) && emit_idx_reg == LAST_IDX)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cmd.seq_bit    = seq_bit;
        cmd.emit_idx   = emit_idx_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            ST_CLOSE:
            begin
                cmd.close = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load  = !out_valid_reg || out_ready;
                cmd.clear = cmd.load && (emit_idx_reg == LAST_IDX);
            end
            default:
            begin
                cmd.close = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        emit_idx_next = emit_idx_reg;
        if (cmd.load)
        begin
            emit_idx_next = cmd.clear ? '0 : emit_idx_reg + IDX_W'(1);
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* hdl/rwevc_dp.sv */
// Datapath of the random walk excursion visit counter: sum, counters, output register.
// Depends on rwevc_pkg for constants, the command struct and the state decode.
`default_nettype none
module rwevc_dp
    import rwevc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rwevc_cmd_t       cmd,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic signed [IDX_W-1:0] walk_state,
    output logic [OUT_W-1:0]      visit_count,
    output logic [OUT_W-1:0]      cycle_count,
    output logic                  applicable,
    output logic                  last_result
);

    localparam int EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0]  zero_reg;
    logic [COUNT_WIDTH-1:0]  cycles_reg;
    logic [COUNT_WIDTH-1:0]  visits_reg [NUM_STATES];
    logic [CFG_W-1:0]        min_cycles_reg;

    logic                    in_span;
    logic [IDX_W-1:0]        vidx;
    logic [IDX_W-1:0]        rd_addr;
    logic [COUNT_WIDTH-1:0]  rd_data;
    logic [EXT_W-1:0]        visits_ext;
    logic [EXT_W-1:0]        cycles_ext;

    logic signed [IDX_W-1:0] walk_state_reg;
    logic [OUT_W-1:0]        visit_count_reg;
    logic [OUT_W-1:0]        cycle_count_reg;
    logic                    applicable_reg;
    logic                    last_result_reg;

    always_comb
    begin
        if (cmd.seq_bit)
        begin
            sum_next = (sum_reg == SUM_MAX) ? sum_reg : sum_reg + SUM_W'(1);
        end
        else
        begin
            sum_next = (sum_reg == SUM_MIN) ? sum_reg : sum_reg - SUM_W'(1);
        end
        in_span = (sum_next >= SPAN_LO) && (sum_next <= SPAN_HI) && (sum_next != '0);
        if (sum_next < 0)
        begin
            vidx = sum_next[IDX_W-1:0] + IDX_W'(STATE_SPAN);
        end
        else
        begin
            vidx = sum_next[IDX_W-1:0] + IDX_W'(STATE_SPAN - 1);
        end
        // Stepping and emitting never overlap, so one read port serves both.
        rd_addr    = cmd.load ? cmd.emit_idx : vidx;
        rd_data    = visits_reg[rd_addr];
        visits_ext = EXT_W'(rd_data);
        cycles_ext = EXT_W'(cycles_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            zero_reg       <= '0;
            cycles_reg     <= '0;
            min_cycles_reg <= MIN_CYCLES_RESET;
            for (int i = 0; i < NUM_STATES; i++)
            begin
                visits_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                min_cycles_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                sum_reg  <= '0;
                zero_reg <= '0;
                for (int i = 0; i < NUM_STATES; i++)
                begin
                    visits_reg[i] <= '0;
                end
            end
            else if (cmd.step)
            begin
                sum_reg <= sum_next;
                if (sum_next == '0)
                begin
                    zero_reg <= (zero_reg == CNT_MAX) ? zero_reg
                                                      : zero_reg + COUNT_WIDTH'(1);
                end
                else if (in_span)
                begin
                    visits_reg[vidx] <= (rd_data == CNT_MAX) ? rd_data
                                                             : rd_data + COUNT_WIDTH'(1);
                end
            end
            // J counts one more cycle when the walk ends away from zero.
            if (cmd.close)
            begin
                cycles_reg <= (sum_reg != '0 && zero_reg != CNT_MAX) ?
                              zero_reg + COUNT_WIDTH'(1) : zero_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            walk_state_reg  <= idx_to_state(cmd.emit_idx);
            visit_count_reg <= (visits_ext > EXT_W'(OUT_MAX)) ? OUT_MAX
                                                              : visits_ext[OUT_W-1:0];
            cycle_count_reg <= (cycles_ext > EXT_W'(OUT_MAX)) ? OUT_MAX
                                                              : cycles_ext[OUT_W-1:0];
            applicable_reg  <= cycles_ext >= EXT_W'(min_cycles_reg);
            last_result_reg <= cmd.emit_idx == LAST_IDX;
        end
    end

    assign walk_state  = walk_state_reg;
    assign visit_count = visit_count_reg;
    assign cycle_count = cycle_count_reg;
    assign applicable  = applicable_reg;
    assign last_result = last_result_reg;

endmodule
`default_nettype wire

/* hdl/random_walk_excursion_visit_counter.sv */
// Random walk excursion visit counter: top level joining controller and datapath.
// Depends on rwevc_pkg, rwevc_if.sv, rwevc_ctrl, rwevc_dp and the defines header.
//
// Usage. Bits of the tested sequence arrive on the bits channel, one request per bit:
// seq_bit steps the running sum up (1) or down (0), and last_bit marks the final bit.
// While accumulating, bits are always taken, so a stream enters at one bit per clock.
// The final bit is taken the same way; the block then forms the cycle count J in its
// close state and then issues 18 requests on the results channel, states -9..-1
// and 1..9, one per cycle while the receiver keeps ready high. The last of them has
// last_result set. While the results are issued the bits channel is held off; the
// single visit counter read port is shared between stepping and emitting.
// A registered output stage holds a result while the receiver stalls; the next bit
// run may already start while the eighteenth result waits there.
// Write min_cycles only while idle; the block does not enforce it. cfg is always ready.
// Reset clears the sum, all counters and the valid flag; min_cycles returns to 500.
// Counters saturate at their full width; reported counts saturate at 32 bits.
`default_nettype none
`include "random_walk_excursion_visit_counter_defines.svh"
module random_walk_excursion_visit_counter
    import rwevc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    rwevc_bit_if.sink      bits,
    rwevc_result_if.source results,
    rwevc_cfg_if.sink      cfg
);

    rwevc_cmd_t cmd;
    logic       in_ready;
    logic       out_valid;

    // Configuration is a plain register write and never stalls.
    assign cfg.ready  = 1'b1;
    assign bits.ready = in_ready;
    assign results.valid = out_valid;

    rwevc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bits.valid),
        .seq_bit   (bits.seq_bit),
        .last_bit  (bits.last_bit),
        .out_ready (results.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    rwevc_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .walk_state  (results.walk_state),
        .visit_count (results.visit_count),
        .cycle_count (results.cycle_count),
        .applicable  (results.applicable),
        .last_result (results.last_result)
    );

    // After a final bit the block must stop taking bits until its results are out.
    `RWEVC_ASSERT_NEXT(a_hold_after_last, clk, rst_n, bits.valid && in_ready && bits.last_bit, !in_ready)
    // Any run returns to zero or ends away from it, so J is never zero.
    `RWEVC_ASSERT_SAME(a_cycles_nonzero, clk, rst_n, out_valid, results.cycle_count != '0)
    // The final result of a run always reports the highest state.
    `RWEVC_ASSERT_SAME(a_last_is_top, clk, rst_n, out_valid && results.last_result, results.walk_state == 5'sd9)

endmodule
`default_nettype wire

/* tb/tb_random_walk_excursion_visit_counter.sv */
`timescale 1ns / 1ps
// Testbench for the random walk excursion visit counter: drives bit runs, checks all 18
// state results of every run against an in-bench tally. Depends on rwevc_pkg, rwevc_if.sv
// and the random_walk_excursion_visit_counter RTL.
module tb_random_walk_excursion_visit_counter;
    import rwevc_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 24;     // settle time after the last owed result, with margin
    localparam int LONG_HOLD     = 200;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BITS    = 22;
    localparam int NUM_DIRECTED  = 25;

    // One row of the directed table. Rows that close a run carry the cycle count and the
    // applicable flag typed in by hand; those replace the tally's own values.
    typedef struct packed {
        logic             up;
        logic             fin;
        logic             typed;
        logic [OUT_W-1:0] cycles;
        logic             app;
    } walk_row_t;

    // One state result as the block must report it.
    typedef struct {
        logic signed [IDX_W-1:0] walk_state;
        logic [OUT_W-1:0]        visits;
        logic [OUT_W-1:0]        cycles;
        logic                    app;
        logic                    fin;
    } state_report_t;

    // Directed runs, all under the reset threshold of 500, so none is applicable:
    // a single up bit, a single down bit, a run that ends back on zero, a climb past +9
    // to +11 and a fall past -9 to -10. Each of them has exactly one excursion cycle.
    localparam walk_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{1'b1, 1'b1, 1'b1, 32'd1, 1'b0},
        '{1'b0, 1'b1, 1'b1, 32'd1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 32'd1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 32'd1, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 32'd1, 1'b0}
    };

    logic clk;
    logic rst_n;

    rwevc_bit_if    bit_ch ();
    rwevc_result_if res_ch ();
    rwevc_cfg_if    cfg_ch ();

    random_walk_excursion_visit_counter #(
        .COUNT_WIDTH (32)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bits    (bit_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // Tally of the walk, kept alongside the block.
    logic signed [SUM_W-1:0] walk_sum;
    logic [OUT_W-1:0]        zero_hits;
    logic [OUT_W-1:0]        state_hits [NUM_STATES];
    logic [CFG_W-1:0]        min_cycles_q;

    // State results still owed by the block, oldest first.
    state_report_t state_reports [$];
    state_report_t oldest;

    bit quiet;          // set for the closing phase: no idling on either side
    bit long_hold_req;  // asks the receiver for one long stall

    int mismatches;
    int bits_taken;
    int runs_done;
    int runs_applicable;
    int results_seen;
    int settings_written;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block wedges.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 LIMIT_CYCLES, state_reports.size());
        $display("FAIL");
        $finish;
    end

    function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Steps the tally by one accepted bit. On the final bit of a run it queues the 18
    // state results, then clears the walk for the next run.
    task automatic walk_and_tally(input logic up, input logic fin, input logic typed,
                                  input logic [OUT_W-1:0] typed_cycles, input logic typed_app);
        logic [OUT_W-1:0] cycles;
        logic             app;
        int               slot;
        state_report_t    row;
        if (up)
        begin
            walk_sum = (walk_sum >= SUM_MAX) ? SUM_MAX : walk_sum + 1;
        end
        else
        begin
            walk_sum = (walk_sum <= SUM_MIN) ? SUM_MIN : walk_sum - 1;
        end
        if (walk_sum == 0)
        begin
            zero_hits = bump(zero_hits);
        end
        else if (walk_sum >= -STATE_SPAN && walk_sum <= STATE_SPAN)
        begin
            // Slots run -9..-1 then +1..+9; zero has no slot of its own.
            slot = (walk_sum < 0) ? int'(walk_sum) + STATE_SPAN
                                  : int'(walk_sum) + STATE_SPAN - 1;
            state_hits[slot] = bump(state_hits[slot]);
        end
        bits_taken++;
        if (fin)
        begin
            // A walk that ends off zero counts one more, unfinished, excursion.
            cycles = (walk_sum != 0) ? bump(zero_hits) : zero_hits;
            app    = (cycles >= min_cycles_q);
            if (typed)
            begin
                cycles = typed_cycles;
                app    = typed_app;
            end
            for (int i = 0; i < NUM_STATES; i++)
            begin
                row.walk_state = (i < STATE_SPAN) ? IDX_W'(i - STATE_SPAN)
                                                  : IDX_W'(i - STATE_SPAN + 1);
                row.visits = state_hits[i];
                row.cycles = cycles;
                row.app    = app;
                row.fin    = (i == NUM_STATES - 1);
                state_reports.push_back(row);
                state_hits[i] = '0;
            end
            walk_sum  = '0;
            zero_hits = '0;
            runs_done++;
            if (app)
            begin
                runs_applicable++;
            end
        end
    endtask

    // Offers one bit request, sometimes after a short idle burst, and waits for it to be
    // taken. valid stays high on return so back-to-back bits need no extra edge.
    task automatic offer_bit(input logic up, input logic fin, input logic typed,
                             input logic [OUT_W-1:0] typed_cycles, input logic typed_app);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            bit_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        bit_ch.valid    <= 1'b1;
        bit_ch.seq_bit  <= up;
        bit_ch.last_bit <= fin;
        @(posedge clk);
        while (!bit_ch.ready)
        begin
            @(posedge clk);
        end
        walk_and_tally(up, fin, typed, typed_cycles, typed_app);
    endtask

    // One complete run: random content with a chosen share of up steps.
    task automatic walk_run(input int len, input int up_pct);
        for (int k = 0; k < len; k++)
        begin
            offer_bit($urandom_range(0, 99) < up_pct, k == len - 1, 1'b0, '0, 1'b0);
        end
    endtask

    // Lets every owed result arrive, then gives the block time to settle back to idle.
    task automatic wait_drained();
        while (state_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_cycles(input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        min_cycles_q = value;
        settings_written++;
    endtask

    // Receiver: ready drops in random bursts, and once for a long stretch so that the
    // output stage fills and the block holds off further bit requests.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 12);
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Checker: every result request taken is compared with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (state_reports.size() == 0)
            begin
                report_mismatch("result with nothing owed", res_ch.visit_count, '0);
            end
            else
            begin
                oldest = state_reports.pop_front();
                if (res_ch.walk_state !== oldest.walk_state)
                begin
                    report_mismatch("walk_state", OUT_W'(res_ch.walk_state),
                                    OUT_W'(oldest.walk_state));
                end
                if (res_ch.visit_count !== oldest.visits)
                begin
                    report_mismatch("visit_count", res_ch.visit_count, oldest.visits);
                end
                if (res_ch.cycle_count !== oldest.cycles)
                begin
                    report_mismatch("cycle_count", res_ch.cycle_count, oldest.cycles);
                end
                if (res_ch.applicable !== oldest.app)
                begin
                    report_mismatch("applicable", OUT_W'(res_ch.applicable), OUT_W'(oldest.app));
                end
                if (res_ch.last_result !== oldest.fin)
                begin
                    report_mismatch("last_result", OUT_W'(res_ch.last_result),
                                    OUT_W'(oldest.fin));
                end
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_min [NUM_PHASES];
        int               pick;
        int               len;
        int               up_pct;
        int               phase_bits;

        mismatches       = 0;
        bits_taken       = 0;
        runs_done        = 0;
        runs_applicable  = 0;
        results_seen     = 0;
        settings_written = 0;
        quiet            = 1'b0;
        long_hold_req    = 1'b0;
        walk_sum         = '0;
        zero_hits        = '0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            state_hits[i] = '0;
        end
        min_cycles_q = MIN_CYCLES_RESET;

        rst_n           <= 1'b0;
        bit_ch.valid    <= 1'b0;
        bit_ch.seq_bit  <= 1'b0;
        bit_ch.last_bit <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed runs under the reset threshold.
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            offer_bit(DIRECTED_ROWS[r].up, DIRECTED_ROWS[r].fin, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].cycles, DIRECTED_ROWS[r].app);
        end
        bit_ch.valid <= 1'b0;

        // Threshold settings: both extremes, small values that random walks straddle (one of
        // them drawn at random), one full-width random value and finally the reset value again.
        phase_min[0] = '0;
        phase_min[1] = '1;
        phase_min[2] = 32'd1;
        phase_min[3] = 32'd2;
        phase_min[4] = 32'd3;
        phase_min[5] = $urandom_range(2, 6);
        phase_min[6] = $urandom;
        phase_min[7] = MIN_CYCLES_RESET;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // The sender pauses here until every owed result has come back.
            wait_drained();
            write_min_cycles(phase_min[p]);
            quiet = (p == NUM_PHASES - 1);
            if (p == 2)
            begin
                long_hold_req = 1'b1;
            end
            phase_bits = 0;
            while (phase_bits < PHASE_BITS)
            begin
                // Mostly balanced walks that cross zero often, some steep walks that
                // leave the -9..+9 window, and a few one- to three-bit runs.
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    len    = $urandom_range(1, 3);
                    up_pct = 50;
                end
                else if (pick < 40)
                begin
                    len    = $urandom_range(10, 30);
                    up_pct = ($urandom_range(0, 1) == 1) ? 85 : 15;
                end
                else
                begin
                    len    = $urandom_range(4, 24);
                    up_pct = 50;
                end
                walk_run(len, up_pct);
                phase_bits += len;
            end
            bit_ch.valid <= 1'b0;
        end

        wait_drained();
        $display("Walked %0d bits in %0d runs under %0d threshold settings; %0d results checked.",
                 bits_taken, runs_done, settings_written, results_seen);
        $display("%0d runs were applicable, %0d were not.",
                 runs_applicable, runs_done - runs_applicable);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
